// ===== rtl/ctp_pkg.sv =====
// Shared types and constants of the compare timer.
package ctp_pkg;

  localparam int unsigned PrescaleBits = 12;
  localparam int unsigned CountBits    = 32;
  localparam int unsigned DataBits     = 32;

  // Control register bits
  localparam int unsigned CtlEnBit  = 0;
  localparam int unsigned CtlFrrBit = 9;
  localparam int unsigned CtlSwrBit = 15;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    REG_CONTROL  = 3'd0,
    REG_PRESCALE = 3'd1,
    REG_STATUS   = 3'd2,
    REG_IRQ_EN   = 3'd3,
    REG_COMPARE1 = 3'd4,
    REG_COUNTER  = 3'd5
  } reg_sel_e;

  typedef struct packed {
    logic [1:0]          action;
    logic [2:0]          reg_sel;
    logic [DataBits-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DataBits-1:0] read_data;
    logic                irq;
    logic                compare_hit;
  } result_t;

endpackage

// ===== rtl/ctp_core.sv =====
// Register file, prescaler, counter and compare logic of the timer.
module ctp_core import ctp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t res_o
);

  logic [DataBits-1:0]     ctrl_q, ctrl_d;
  logic [PrescaleBits-1:0] pv_q, pv_d;
  logic [PrescaleBits-1:0] pc_q, pc_d;
  logic [CountBits-1:0]    cnt_q, cnt_d;
  logic [CountBits-1:0]    cmp_q, cmp_d;
  logic                    flag_q, flag_d;
  logic                    ien_q, ien_d;

  logic                    tick_en;
  logic                    wrap;
  logic [CountBits-1:0]    cnt_next;
  logic                    hit;
  logic                    is_read;
  logic                    is_write;
  logic                    soft_rst;
  logic [DataBits-1:0]     rd_data;

  assign tick_en  = fire_i && (item_i.action == ACT_TICK) && ctrl_q[CtlEnBit];
  assign is_read  = fire_i && (item_i.action == ACT_READ);
  assign is_write = fire_i && (item_i.action == ACT_WRITE);
  assign soft_rst = is_write && (item_i.reg_sel == REG_CONTROL) &&
                    item_i.write_data[CtlSwrBit];

  assign wrap     = (pc_q >= pv_q);
  // restart mode drops back to zero once the compare value has been reached
  assign cnt_next = (!ctrl_q[CtlFrrBit] && (cnt_q == cmp_q)) ? '0 : cnt_q + 1'b1;
  assign hit      = tick_en && wrap && (cnt_next == cmp_q);

  always_comb begin
    case (item_i.reg_sel)
      REG_CONTROL:  rd_data = ctrl_q;
      REG_PRESCALE: rd_data = DataBits'(pv_q);
      REG_STATUS:   rd_data = DataBits'(flag_q);
      REG_IRQ_EN:   rd_data = DataBits'(ien_q);
      REG_COMPARE1: rd_data = DataBits'(cmp_q);
      REG_COUNTER:  rd_data = DataBits'(cnt_q);
      default:      rd_data = '0;
    endcase
  end

  always_comb begin
    ctrl_d = ctrl_q;
    pv_d   = pv_q;
    pc_d   = pc_q;
    cnt_d  = cnt_q;
    cmp_d  = cmp_q;
    flag_d = flag_q;
    ien_d  = ien_q;
    if (tick_en) begin
      if (wrap) begin
        pc_d  = '0;
        cnt_d = cnt_next;
        if (hit) flag_d = 1'b1;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
    if (soft_rst) begin
      ctrl_d = '0;
      pv_d   = '0;
      pc_d   = '0;
      cnt_d  = '0;
      cmp_d  = '1;
      flag_d = 1'b0;
      ien_d  = 1'b0;
    end else if (is_write) begin
      case (item_i.reg_sel)
        REG_CONTROL:  ctrl_d = item_i.write_data;
        REG_PRESCALE: pv_d   = item_i.write_data[PrescaleBits-1:0];
        REG_STATUS:   if (item_i.write_data[0]) flag_d = 1'b0;
        REG_IRQ_EN:   ien_d  = item_i.write_data[0];
        REG_COMPARE1: cmp_d  = item_i.write_data[CountBits-1:0];
        default:      ;  // counter is read only; drop the rest
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      pv_q   <= '0;
      pc_q   <= '0;
      cnt_q  <= '0;
      cmp_q  <= '1;
      flag_q <= 1'b0;
      ien_q  <= 1'b0;
    end else begin
      ctrl_q <= ctrl_d;
      pv_q   <= pv_d;
      pc_q   <= pc_d;
      cnt_q  <= cnt_d;
      cmp_q  <= cmp_d;
      flag_q <= flag_d;
      ien_q  <= ien_d;
    end
  end

  assign res_o.read_data   = is_read ? rd_data : '0;
  assign res_o.irq         = flag_d & ien_d;
  assign res_o.compare_hit = hit;

  a_hit_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |=> flag_q)
    else $error("compare hit did not set the flag");

  a_disabled_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.action == ACT_TICK && !ctrl_q[CtlEnBit]) |=>
      ($stable(cnt_q) && $stable(pc_q)))
    else $error("disabled timer advanced");

  a_soft_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    soft_rst |=> (ctrl_q == '0 && cnt_q == '0 && cmp_q == '1 && !flag_q && !ien_q))
    else $error("soft reset did not restore registers");

  a_swr_never_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_q[CtlSwrBit])
    else $error("soft reset bit stored");

  a_count_moves_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!is_write && !(tick_en && wrap)) |=> $stable(cnt_q))
    else $error("counter changed without a prescaler wrap");

endmodule

// ===== rtl/compare_timer_with_prescaler.sv =====
// Top level of the compare timer: handshake and result register.
//
// Every accepted word (tick, register read or register write) yields exactly
// one result word, in the cycle after acceptance. A word can be accepted in
// every cycle: the register update and the result are computed in one pass
// and the result lands in a single output register, so in_ready_o is high
// whenever that register is empty or is being taken in the same cycle. The
// sustained rate is one word per clock; the output register is the only
// stage. Ticks advance the prescaler only while the enable bit of the control
// register is set; a control write with the soft reset bit restores all
// registers at once. The interrupt output reflects the state after each word.
module compare_timer_with_prescaler import ctp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          action_i,
  input  logic [2:0]          reg_sel_i,
  input  logic [DataBits-1:0] write_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DataBits-1:0] read_data_o,
  output logic                irq_o,
  output logic                compare_hit_o
);

  logic    out_valid_q, out_valid_d;
  result_t res_q;
  result_t res;
  item_t   item;
  logic    fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  assign item.action     = action_i;
  assign item.reg_sel    = reg_sel_i;
  assign item.write_data = write_data_i;

  ctp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item),
    .res_o  (res)
  );

  // hold the result until taken, refill on accept
  assign out_valid_d = fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = res_q.read_data;
  assign irq_o         = res_q.irq;
  assign compare_hit_o = res_q.compare_hit;

endmodule
